// ----- design/lsj_pkg.sv -----
package lsj_pkg;

	// Fixed field widths of the channels
	localparam int RANGE_W   = 16;
	localparam int IDX_W     = 10;
	localparam int BC_W      = 11;
	localparam int TH_W      = 16;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 16;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_BEAM_COUNT     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_JUMP_THRESHOLD = 4'd1;

	// Register reset values and limits
	localparam logic [BC_W-1:0] BEAM_COUNT_RST = 11'd720;
	localparam logic [TH_W-1:0] THRESHOLD_RST  = 16'd650;
	localparam int              MIN_BEAMS      = 3;

	// Request from the sequencer to the span output stage
	typedef struct packed {
		logic             span;
		logic             finish;
		logic [IDX_W-1:0] start_idx;
		logic [IDX_W-1:0] end_idx;
	} span_req_t;

endpackage

// ----- design/lsj_ifs.sv -----
interface lsj_sample_if;
	logic                      valid;
	logic                      ready;
	logic [lsj_pkg::RANGE_W-1:0] range_mm;
	logic                      range_infinite;

	modport source (output valid, output range_mm, output range_infinite, input ready);
	modport sink (input valid, input range_mm, input range_infinite, output ready);
endinterface

interface lsj_span_if;
	logic                      valid;
	logic                      ready;
	logic [lsj_pkg::IDX_W-1:0] span_start;
	logic [lsj_pkg::IDX_W-1:0] span_end;
	logic                      span_valid;
	logic                      span_overflow;
	logic                      last_span;

	modport source (output valid, output span_start, output span_end, output span_valid,
		output span_overflow, output last_span, input ready);
	modport sink (input valid, input span_start, input span_end, input span_valid,
		input span_overflow, input last_span, output ready);
endinterface

interface lsj_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [lsj_pkg::CFG_IDX_W-1:0] index;
	logic [lsj_pkg::CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/lsj_scan_mem.sv -----
module lsj_scan_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 17
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/lsj_jump_cmp.sv -----
module lsj_jump_cmp #(
	parameter int RANGE_BITS = 16
) (
	input  logic [RANGE_BITS:0]          a,
	input  logic [RANGE_BITS:0]          b,
	input  logic [lsj_pkg::TH_W-1:0]     thr,
	output logic                         drop,
	output logic                         rise
);

	localparam int CW = (RANGE_BITS > lsj_pkg::TH_W) ? RANGE_BITS : lsj_pkg::TH_W;

	logic                  a_inf;
	logic                  b_inf;
	logic [RANGE_BITS:0]   diff;
	logic                  neg;
	logic [RANGE_BITS-1:0] mag;
	logic [CW-1:0]         mag_x;
	logic [CW-1:0]         thr_x;
	logic                  big;

	assign a_inf = a[RANGE_BITS];
	assign b_inf = b[RANGE_BITS];

	// Signed difference of the finite parts, then its magnitude
	assign diff  = {1'b0, a[RANGE_BITS-1:0]} - {1'b0, b[RANGE_BITS-1:0]};
	assign neg   = diff[RANGE_BITS];
	assign mag   = neg ? (-diff[RANGE_BITS-1:0]) : diff[RANGE_BITS-1:0];
	assign mag_x = CW'(mag);
	assign thr_x = CW'(thr);
	assign big   = (mag_x >= thr_x);

	// Infinity is always a jump against a finite sample, never against another
	assign drop = a_inf ? !b_inf : (!b_inf && !neg && big);
	assign rise = b_inf ? !a_inf : (!a_inf && neg && big);

endmodule

// ----- design/lsj_span_out.sv -----
module lsj_span_out #(
	parameter int MAX_SPANS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lsj_pkg::span_req_t req,
	output logic               stall,
	lsj_span_if.source         spans
);

	localparam int CNT_W = $clog2(MAX_SPANS + 1);

	logic                        pend_v_q;
	logic [lsj_pkg::IDX_W-1:0]   pend_s_q;
	logic [lsj_pkg::IDX_W-1:0]   pend_e_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        ovf_q;
	logic                        out_v_q;
	logic [lsj_pkg::IDX_W-1:0]   out_s_q;
	logic [lsj_pkg::IDX_W-1:0]   out_e_q;
	logic                        out_sv_q;
	logic                        out_ovf_q;
	logic                        out_last_q;

	logic free;
	logic full;
	logic take;
	logic push_pend;
	logic push_fin;
	logic push;

	// The newest span waits in the pending slot until it is known whether it is the last
	assign free      = !out_v_q || spans.ready;
	assign full      = (cnt_q == CNT_W'(MAX_SPANS));
	assign take      = req.span && !full;
	assign push_pend = take && pend_v_q;
	assign push_fin  = req.finish;
	assign push      = push_pend || push_fin;
	assign stall     = push && !free;

	// Pending slot, span count and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
		end else if (!stall) begin
			if (take) begin
				pend_v_q <= 1'b1;
				cnt_q    <= cnt_q + CNT_W'(1);
			end
			if (req.span && full) begin
				ovf_q <= 1'b1;
			end
			if (push_fin) begin
				pend_v_q <= 1'b0;
				cnt_q    <= '0;
				ovf_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && !stall) begin
			pend_s_q <= req.start_idx;
			pend_e_q <= req.end_idx;
		end
	end

	// Output register: drop on a taken beat, load on a push
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (push && free) begin
			out_v_q <= 1'b1;
		end else if (spans.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push && free) begin
			if (push_fin) begin
				out_s_q    <= pend_v_q ? pend_s_q : '0;
				out_e_q    <= pend_v_q ? pend_e_q : '0;
				out_sv_q   <= pend_v_q;
				out_ovf_q  <= pend_v_q && ovf_q;
				out_last_q <= 1'b1;
			end else begin
				out_s_q    <= pend_s_q;
				out_e_q    <= pend_e_q;
				out_sv_q   <= 1'b1;
				out_ovf_q  <= 1'b0;
				out_last_q <= 1'b0;
			end
		end
	end

	assign spans.valid         = out_v_q;
	assign spans.span_start    = out_s_q;
	assign spans.span_end      = out_e_q;
	assign spans.span_valid    = out_sv_q;
	assign spans.span_overflow = out_ovf_q;
	assign spans.last_span     = out_last_q;

endmodule

// ----- design/lidar_scan_jump_segmenter_unit.sv -----
// Lidar scan jump segmenter.
// samples: one range beat per beam (range_mm, range_infinite). The beat that
//   brings the count to beam_count (clamped to 3..MAX_BEAMS) closes the scan.
// spans: one beat per clear span, up to MAX_SPANS, in beam order from the
//   first jump; the final beat of a scan has last_span set. A scan with no
//   clear span gives a single beat with span_valid low.
// cfg: register writes (index 0 beam_count, 1 jump_threshold_mm), always ready.
// After the closing beat the block runs three passes over the scan memory
//   through its single registered read port: fill, jump search and marking
//   with the closing step. samples.ready is low during the passes.
// The last span of a scan waits in a pending slot until the scan ends, so the
//   spans show up on the output register as the marking pass goes.
// When the receiver stalls the output register holds its beat, and the
//   marking pass waits on a span until the register frees up.
// Reset returns the registers to 720 beams and 650 mm and empties the
//   load count and output; the scan memory is not cleared.
module lidar_scan_jump_segmenter_unit #(
	parameter int MAX_BEAMS  = 1024,
	parameter int MAX_SPANS  = 32,
	parameter int RANGE_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	lsj_sample_if.sink   samples,
	lsj_span_if.source   spans,
	lsj_cfg_if.sink      cfg
);

	localparam int AW = $clog2(MAX_BEAMS);
	localparam int NW = $clog2(MAX_BEAMS + 1);
	localparam int EW = RANGE_BITS + 1;

	localparam logic [3:0] ST_LOAD  = 4'd0;
	localparam logic [3:0] ST_F_RD0 = 4'd1;
	localparam logic [3:0] ST_F_LD0 = 4'd2;
	localparam logic [3:0] ST_F_LD1 = 4'd3;
	localparam logic [3:0] ST_F_RD  = 4'd4;
	localparam logic [3:0] ST_F_EX  = 4'd5;
	localparam logic [3:0] ST_J_RD0 = 4'd6;
	localparam logic [3:0] ST_J_LD  = 4'd7;
	localparam logic [3:0] ST_J_RD  = 4'd8;
	localparam logic [3:0] ST_J_EX  = 4'd9;
	localparam logic [3:0] ST_M_RD0 = 4'd10;
	localparam logic [3:0] ST_M_LD  = 4'd11;
	localparam logic [3:0] ST_M_RD  = 4'd12;
	localparam logic [3:0] ST_M_EX  = 4'd13;
	localparam logic [3:0] ST_FIN   = 4'd14;

	function automatic logic [AW-1:0] wrap_inc(logic [AW-1:0] x, logic [NW-1:0] cnt);
		logic [NW-1:0] nx;
		nx = NW'(x) + NW'(1);
		return (nx == cnt) ? '0 : x + AW'(1);
	endfunction

	function automatic logic [lsj_pkg::IDX_W-1:0] to_idx(logic [AW-1:0] x);
		logic [31:0] wide;
		wide = 32'(x);
		return wide[lsj_pkg::IDX_W-1:0];
	endfunction

	logic [lsj_pkg::BC_W-1:0] beam_count_q;
	logic [lsj_pkg::TH_W-1:0] thresh_q;

	logic [3:0]    state_q;
	logic [NW-1:0] lc_q;
	logic [AW-1:0] i_q;
	logic [AW-1:0] z_q;
	logic [AW-1:0] start_q;
	logic [EW-1:0] w0_q;
	logic [EW-1:0] w1_q;
	logic [EW-1:0] orig0_q;
	logic [EW-1:0] upd1_q;
	logic          kind_drop_q;
	logic          obst_q;
	logic          clear_q;

	logic [31:0]              bc32;
	logic [NW-1:0]            n_eff;
	logic [NW-1:0]            n_m1;
	logic [lsj_pkg::TH_W-1:0] thr;
	logic [NW-1:0]            lc_next;
	logic                     load_beat;
	logic [31:0]              rng32;

	logic [AW-1:0] inc_i;
	logic [AW-1:0] nx_i;
	logic [AW-1:0] dec_i;
	logic          i_last;
	logic          m_last;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [EW-1:0] rd_data;

	logic          drop;
	logic          rise;

	logic [EW-1:0] fill_c;
	logic          fill;
	logic [EW-1:0] w1_new;

	logic          clr_n;
	logic [AW-1:0] st_n;
	logic          obst_n;

	lsj_pkg::span_req_t req;
	logic               stall;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_count_q <= lsj_pkg::BEAM_COUNT_RST;
			thresh_q     <= lsj_pkg::THRESHOLD_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				lsj_pkg::CFG_BEAM_COUNT:     beam_count_q <= cfg.data[lsj_pkg::BC_W-1:0];
				lsj_pkg::CFG_JUMP_THRESHOLD: thresh_q     <= cfg.data[lsj_pkg::TH_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective beam count and threshold
	assign bc32  = 32'(beam_count_q);
	assign n_eff = (bc32 < 32'(lsj_pkg::MIN_BEAMS)) ? NW'(lsj_pkg::MIN_BEAMS) :
		(bc32 > 32'(MAX_BEAMS)) ? NW'(MAX_BEAMS) : NW'(bc32);
	assign n_m1  = n_eff - NW'(1);
	assign thr   = (thresh_q == '0) ? lsj_pkg::TH_W'(1) : thresh_q;

	// Circular index arithmetic around the current beam
	assign inc_i  = wrap_inc(i_q, n_eff);
	assign nx_i   = wrap_inc(inc_i, n_eff);
	assign dec_i  = (i_q == '0) ? n_m1[AW-1:0] : i_q - AW'(1);
	assign i_last = (NW'(i_q) == n_m1);
	assign m_last = (inc_i == z_q);

	// Sample loading
	assign samples.ready = (state_q == ST_LOAD);
	assign load_beat     = samples.valid && samples.ready;
	assign lc_next       = lc_q + NW'(1);
	assign rng32         = 32'(samples.range_mm);

	// Fill step: an isolated no-echo sample takes the finite sample before it
	assign fill_c = (nx_i == '0) ? orig0_q : (nx_i == AW'(1)) ? upd1_q : rd_data;
	assign fill   = !w0_q[EW-1] && w1_q[EW-1] && !fill_c[EW-1];
	assign w1_new = fill ? w0_q : w1_q;

	// Shared jump compare on the current and next sample
	lsj_jump_cmp #(
		.RANGE_BITS (RANGE_BITS)
	) u_cmp (
		.a    (w0_q),
		.b    (rd_data),
		.thr  (thr),
		.drop (drop),
		.rise (rise)
	);

	// Marking step: toggle state and track clear spans
	always_comb begin
		clr_n         = clear_q;
		st_n          = start_q;
		req.span      = 1'b0;
		req.finish    = (state_q == ST_FIN);
		req.start_idx = to_idx(start_q);
		req.end_idx   = to_idx(dec_i);
		if (!clear_q && !obst_q) begin
			clr_n = 1'b1;
			st_n  = i_q;
		end else if (clear_q && obst_q) begin
			clr_n    = 1'b0;
			req.span = (state_q == ST_M_EX);
		end
		if (m_last && clr_n) begin
			req.span      = (state_q == ST_M_EX);
			req.start_idx = to_idx(st_n);
			req.end_idx   = to_idx(i_q);
		end
		obst_n = ((!obst_q && drop) || (obst_q && rise)) ? !obst_q : obst_q;
	end

	// Memory port selection
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = lc_q[AW-1:0];
		mem_wdata = {samples.range_infinite, rng32[RANGE_BITS-1:0]};
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			ST_LOAD: begin
				mem_we = load_beat;
			end
			ST_F_RD0, ST_J_RD0: begin
				mem_re = 1'b1;
			end
			ST_F_LD0: begin
				mem_re    = 1'b1;
				mem_raddr = AW'(1);
			end
			ST_F_RD: begin
				mem_re    = 1'b1;
				mem_raddr = nx_i;
			end
			ST_F_EX: begin
				mem_we    = fill;
				mem_waddr = inc_i;
				mem_wdata = w0_q;
			end
			ST_J_RD, ST_M_RD: begin
				mem_re    = 1'b1;
				mem_raddr = inc_i;
			end
			ST_M_RD0: begin
				mem_re    = 1'b1;
				mem_raddr = z_q;
			end
			default: ;
		endcase
	end

	lsj_scan_mem #(
		.DEPTH (MAX_BEAMS),
		.WIDTH (EW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd_data)
	);

	lsj_span_out #(
		.MAX_SPANS (MAX_SPANS)
	) u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.stall  (stall),
		.spans  (spans)
	);

	// Sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			lc_q    <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (load_beat) begin
						if (lc_next >= n_eff) begin
							lc_q    <= '0;
							state_q <= ST_F_RD0;
						end else begin
							lc_q <= lc_next;
						end
					end
				end
				ST_F_RD0: state_q <= ST_F_LD0;
				ST_F_LD0: state_q <= ST_F_LD1;
				ST_F_LD1: state_q <= ST_F_RD;
				ST_F_RD:  state_q <= ST_F_EX;
				ST_F_EX:  state_q <= i_last ? ST_J_RD0 : ST_F_RD;
				ST_J_RD0: state_q <= ST_J_LD;
				ST_J_LD:  state_q <= ST_J_RD;
				ST_J_RD:  state_q <= ST_J_EX;
				ST_J_EX:  state_q <= (drop || rise || i_last) ? ST_M_RD0 : ST_J_RD;
				ST_M_RD0: state_q <= ST_M_LD;
				ST_M_LD:  state_q <= ST_M_RD;
				ST_M_RD:  state_q <= ST_M_EX;
				ST_M_EX: begin
					if (!stall) begin
						state_q <= m_last ? ST_FIN : ST_M_RD;
					end
				end
				ST_FIN: begin
					if (!stall) begin
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// Sequencer datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_F_LD0: begin
				orig0_q <= rd_data;
				w0_q    <= rd_data;
			end
			ST_F_LD1: begin
				w1_q <= rd_data;
				i_q  <= '0;
			end
			ST_F_EX: begin
				if (i_q == '0) begin
					upd1_q <= w1_new;
				end
				w0_q <= w1_new;
				w1_q <= fill_c;
				i_q  <= inc_i;
			end
			ST_J_LD: begin
				w0_q <= rd_data;
				i_q  <= '0;
			end
			ST_J_EX: begin
				if (drop || rise) begin
					kind_drop_q <= drop;
					z_q         <= inc_i;
				end else if (i_last) begin
					kind_drop_q <= 1'b0;
					z_q         <= AW'(1);
				end else begin
					w0_q <= rd_data;
					i_q  <= inc_i;
				end
			end
			ST_M_LD: begin
				w0_q    <= rd_data;
				i_q     <= z_q;
				obst_q  <= kind_drop_q;
				clear_q <= !kind_drop_q;
				start_q <= z_q;
			end
			ST_M_EX: begin
				if (!stall) begin
					clear_q <= clr_n;
					start_q <= st_n;
					obst_q  <= obst_n;
					w0_q    <= rd_data;
					i_q     <= inc_i;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;

	localparam int MAX_BEAMS     = 1024;
	localparam int MAX_SPANS     = 32;
	localparam int RANDOM_ITEMS  = 12;
	localparam int MIN_SPANS     = 40;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 3000;
	localparam int TAIL_CYCLES   = 64;

	typedef struct packed {
		logic [lsj_pkg::RANGE_W-1:0] range_mm;
		logic                        no_echo;
	} beam_t;

	typedef struct packed {
		logic [lsj_pkg::IDX_W-1:0] start_idx;
		logic [lsj_pkg::IDX_W-1:0] end_idx;
		logic                      has_span;
		logic                      dropped;
		logic                      closing;
	} span_beat_t;

	typedef enum {JUMP_NONE, JUMP_DROP, JUMP_RISE} jump_t;
	typedef enum {STYLE_SEGMENTS, STYLE_TOGGLE, STYLE_NOISE} scan_style_t;

	logic clk;
	logic arst_n;

	lsj_sample_if smp ();
	lsj_span_if   spn ();
	lsj_cfg_if    cfgc ();

	lidar_scan_jump_segmenter_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (smp),
		.spans   (spn),
		.cfg     (cfgc)
	);

	// Stimulus and scoreboard state
	beam_t       pending_beams [$];
	span_beat_t  expected_spans [$];
	int unsigned beams_queued;
	int unsigned beams_taken;
	int unsigned spans_predicted;
	int unsigned errors;
	bit          calm;
	bit          hold_arm;
	bit          hold_done;
	int unsigned hold_left;
	int unsigned send_gap;
	int unsigned rx_stall;
	beam_t       next_beam;
	span_beat_t  got_beat;
	span_beat_t  want_beat;

	// Shadow of the block: register copies, scan memory, marks
	logic [lsj_pkg::BC_W-1:0]  cfg_beams;
	logic [lsj_pkg::TH_W-1:0]  cfg_thresh;
	int unsigned               beams_loaded;
	logic [lsj_pkg::RANGE_W:0] range_mem [MAX_BEAMS];
	bit                        blocked [MAX_BEAMS];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("lidar_scan_jump_segmenter_unit regression: fail");
		$finish;
	end

	task automatic flag_mismatch(string what);
		$display("MISMATCH at %0t: %s", $time, what);
		errors++;
	endtask

	function automatic string beat_str(span_beat_t b);
		return $sformatf("start %0d end %0d valid %0b ovf %0b last %0b",
			b.start_idx, b.end_idx, b.has_span, b.dropped, b.closing);
	endfunction

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// True when going from a to b is a drop of at least thr
	function automatic bit is_drop(logic [lsj_pkg::RANGE_W:0] a, logic [lsj_pkg::RANGE_W:0] b,
			int unsigned thr);
		int unsigned av;
		int unsigned bv;
		av = a[lsj_pkg::RANGE_W-1:0];
		bv = b[lsj_pkg::RANGE_W-1:0];
		if (a[lsj_pkg::RANGE_W])
			return !b[lsj_pkg::RANGE_W];
		if (b[lsj_pkg::RANGE_W])
			return 1'b0;
		return (av > bv) && ((av - bv) >= thr);
	endfunction

	function automatic span_beat_t make_beat(int unsigned s, int unsigned e, bit has);
		span_beat_t b;
		b.start_idx = s[lsj_pkg::IDX_W-1:0];
		b.end_idx   = e[lsj_pkg::IDX_W-1:0];
		b.has_span  = has;
		b.dropped   = 1'b0;
		b.closing   = !has;
		return b;
	endfunction

	// Load one beam; on the closing beam segment the scan and queue its spans
	task automatic absorb_beam(logic [lsj_pkg::RANGE_W-1:0] range_mm, logic no_echo);
		int unsigned n, thr, i, k, nx, z, lastb, start, total, idx;
		jump_t       kind;
		bit          obst;
		bit          clr;
		logic [lsj_pkg::RANGE_W:0] a, b;
		span_beat_t  found [$];

		n = cfg_beams;
		if (n < lsj_pkg::MIN_BEAMS)
			n = lsj_pkg::MIN_BEAMS;
		if (n > MAX_BEAMS)
			n = MAX_BEAMS;
		thr = (cfg_thresh == 0) ? 1 : cfg_thresh;

		if (beams_loaded < MAX_BEAMS)
			range_mem[beams_loaded] = {no_echo, range_mm};
		beams_loaded++;
		if (beams_loaded < n)
			return;
		beams_loaded = 0;

		// fill isolated no-echo beams from the beam before, in order
		for (i = 0; i < n; i++) begin
			k = (i + 1) % n;
			nx = (k + 1) % n;
			if (!range_mem[i][lsj_pkg::RANGE_W] && range_mem[k][lsj_pkg::RANGE_W]
					&& !range_mem[nx][lsj_pkg::RANGE_W])
				range_mem[k] = range_mem[i];
		end

		// find the first jump
		kind = JUMP_NONE;
		for (i = 0; i < n; i++) begin
			a = range_mem[i];
			b = range_mem[(i + 1) % n];
			if (is_drop(a, b, thr)) begin
				kind = JUMP_DROP;
				break;
			end
			if (is_drop(b, a, thr)) begin
				kind = JUMP_RISE;
				break;
			end
		end
		z = (i + 1) % n;
		lastb = (z + n - 1) % n;

		// mark beams, toggling on a drop while clear and a rise while blocked
		obst = (kind == JUMP_DROP);
		i = z;
		for (k = 0; k < n; k++) begin
			a = range_mem[i];
			b = range_mem[(i + 1) % n];
			blocked[i] = obst;
			if ((!obst && is_drop(a, b, thr)) || (obst && is_drop(b, a, thr)))
				obst = !obst;
			i = (i + 1) % n;
		end

		// collect clear spans
		clr = !blocked[z];
		start = z;
		total = 0;
		i = z;
		for (k = 0; k < n; k++) begin
			if (!clr && !blocked[i]) begin
				clr = 1'b1;
				start = i;
			end else if (clr && blocked[i]) begin
				clr = 1'b0;
				if (found.size() < MAX_SPANS)
					found.push_back(make_beat(start, (i + n - 1) % n, 1'b1));
				total++;
			end
			if (i == lastb && clr) begin
				if (found.size() < MAX_SPANS)
					found.push_back(make_beat(start, i, 1'b1));
				total++;
			end
			i = (i + 1) % n;
		end

		if (found.size() == 0) begin
			found.push_back(make_beat(0, 0, 1'b0));
		end else begin
			idx = found.size() - 1;
			found[idx].dropped = (total > MAX_SPANS);
			found[idx].closing = 1'b1;
		end
		foreach (found[j])
			expected_spans.push_back(found[j]);
		spans_predicted += found.size();
	endtask

	// Sample driver: offer queued beams with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp.valid <= 1'b0;
			smp.range_mm <= '0;
			smp.range_infinite <= 1'b0;
			send_gap = 0;
		end else begin
			if (smp.valid && smp.ready) begin
				absorb_beam(smp.range_mm, smp.range_infinite);
				beams_taken++;
			end
			if (!smp.valid || smp.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					smp.valid <= 1'b0;
				end else if (pending_beams.size() > 0) begin
					next_beam = pending_beams.pop_front();
					smp.valid <= 1'b1;
					smp.range_mm <= next_beam.range_mm;
					smp.range_infinite <= next_beam.no_echo;
					send_gap = calm ? 0 : idle_len();
				end else begin
					smp.valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, started once on the first span beat after arming
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_arm && !hold_done && spn.valid) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// Span monitor: check each beat against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spn.ready <= 1'b0;
			rx_stall = 0;
		end else begin
			if (spn.valid && spn.ready) begin
				got_beat = {spn.span_start, spn.span_end, spn.span_valid,
					spn.span_overflow, spn.last_span};
				if (expected_spans.size() == 0) begin
					flag_mismatch({"unexpected span beat: ", beat_str(got_beat)});
				end else begin
					want_beat = expected_spans.pop_front();
					if (got_beat !== want_beat)
						flag_mismatch({"got ", beat_str(got_beat), " want ", beat_str(want_beat)});
				end
			end
			if (rx_stall > 0)
				rx_stall--;
			else
				rx_stall = calm ? 0 : idle_len();
			spn.ready <= (rx_stall == 0) && (hold_left == 0);
		end
	end

	task automatic write_reg(logic [lsj_pkg::CFG_IDX_W-1:0] idx,
			logic [lsj_pkg::CFG_DAT_W-1:0] value);
		@(posedge clk);
		cfgc.valid <= 1'b1;
		cfgc.index <= idx;
		cfgc.data <= value;
		do @(posedge clk); while (!cfgc.ready);
		if (idx == lsj_pkg::CFG_BEAM_COUNT)
			cfg_beams = value[lsj_pkg::BC_W-1:0];
		else if (idx == lsj_pkg::CFG_JUMP_THRESHOLD)
			cfg_thresh = value[lsj_pkg::TH_W-1:0];
		cfgc.valid <= 1'b0;
	endtask

	task automatic put_beam(int unsigned range_mm, bit no_echo);
		beam_t b;
		b.range_mm = range_mm[lsj_pkg::RANGE_W-1:0];
		b.no_echo = no_echo;
		pending_beams.push_back(b);
		beams_queued++;
	endtask

	// Wait until every beam went in and every span came out
	task automatic settle();
		while (pending_beams.size() != 0 || beams_taken != beams_queued
				|| expected_spans.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_scan(int unsigned n, scan_style_t style, int unsigned thr);
		int unsigned i, level, seg_left, v;
		bit          seg_dark;
		bit          no_echo;
		level = 0;
		seg_left = 0;
		seg_dark = 1'b0;
		for (i = 0; i < n; i++) begin
			no_echo = 1'b0;
			case (style)
				STYLE_TOGGLE: begin
					v = i[0] ? 6000 + $urandom_range(0, 99) : $urandom_range(0, 999);
				end
				STYLE_NOISE: begin
					v = $urandom_range(0, 65535);
					no_echo = ($urandom_range(0, 3) == 0);
				end
				default: begin
					// piecewise level with jitter below the threshold
					if (seg_left == 0) begin
						level = $urandom_range(0, 65535);
						seg_left = $urandom_range(1, 6);
						seg_dark = ($urandom_range(0, 9) == 0);
					end
					seg_left--;
					v = level + $urandom_range(0, thr / 4);
					if (v > 65535)
						v = 65535;
					no_echo = seg_dark || ($urandom_range(0, 99) < 6);
				end
			endcase
			put_beam(v, no_echo);
		end
	endtask

	initial begin
		int unsigned n, thr, scans, rnd_items, span_mark, phase, r;
		scan_style_t style;

		calm = 1'b0;
		hold_arm = 1'b0;
		errors = 0;
		beams_queued = 0;
		beams_taken = 0;
		spans_predicted = 0;
		arst_n = 1'b0;
		cfgc.valid = 1'b0;
		cfgc.index = lsj_pkg::CFG_BEAM_COUNT;
		cfgc.data = '0;
		cfg_beams = lsj_pkg::BEAM_COUNT_RST;
		cfg_thresh = lsj_pkg::THRESHOLD_RST;
		beams_loaded = 0;

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// zero count and zero threshold both clamp; full-scale swing
		write_reg(lsj_pkg::CFG_BEAM_COUNT, 16'd0);
		write_reg(lsj_pkg::CFG_JUMP_THRESHOLD, 16'd0);
		put_beam(0, 0); put_beam(65535, 0); put_beam(0, 0);
		settle();

		// jump exactly at the top threshold
		write_reg(lsj_pkg::CFG_BEAM_COUNT, 16'd2);
		write_reg(lsj_pkg::CFG_JUMP_THRESHOLD, 16'd65535);
		put_beam(65535, 0); put_beam(0, 0); put_beam(65535, 0);
		settle();

		// flat scan: no jump anywhere
		write_reg(lsj_pkg::CFG_BEAM_COUNT, 16'd3);
		write_reg(lsj_pkg::CFG_JUMP_THRESHOLD, 16'd650);
		put_beam(5, 0); put_beam(5, 0); put_beam(5, 0);
		settle();

		// one drop, slow climb back: every beam blocked, no clear span
		write_reg(lsj_pkg::CFG_JUMP_THRESHOLD, 16'd150);
		put_beam(200, 0); put_beam(0, 0); put_beam(100, 0);
		settle();

		// isolated no-echo beams get filled; a pair of them stays
		write_reg(lsj_pkg::CFG_BEAM_COUNT, 16'd4);
		write_reg(lsj_pkg::CFG_JUMP_THRESHOLD, 16'd650);
		put_beam(1000, 0); put_beam(0, 1); put_beam(1000, 0); put_beam(65535, 1);
		settle();
		put_beam(1000, 0); put_beam(12, 1); put_beam(40000, 1); put_beam(3000, 0);
		settle();

		// shrink the beam count partway through loading
		write_reg(lsj_pkg::CFG_BEAM_COUNT, 16'd8);
		put_beam(100, 0); put_beam(2000, 0); put_beam(2000, 0); put_beam(100, 0);
		put_beam(0, 1);
		settle();
		write_reg(lsj_pkg::CFG_BEAM_COUNT, 16'd4);
		put_beam(7, 0);
		settle();

		// random phases: mostly small scans and one overflowing pair
		rnd_items = 0;
		span_mark = spans_predicted;
		phase = 0;
		while (phase < 2 || rnd_items < RANDOM_ITEMS
				|| spans_predicted - span_mark < MIN_SPANS) begin
			calm = 1'b0;
			scans = $urandom_range(1, 3);
			r = $urandom_range(0, 99);
			style = (r < 70) ? STYLE_SEGMENTS : (r < 85) ? STYLE_NOISE : STYLE_TOGGLE;
			r = $urandom_range(0, 99);
			if (r < 15)
				thr = 1;
			else if (r < 25)
				thr = 65535;
			else if (r < 65)
				thr = 650;
			else
				thr = $urandom_range(1, 3000);
			r = $urandom_range(0, 99);
			if (r < 70)
				n = $urandom_range(3, 12);
			else if (r < 95)
				n = $urandom_range(13, 40);
			else
				n = $urandom_range(41, 64);
			calm = ($urandom_range(0, 4) == 0);

			if (phase == 1) begin
				// more spans than fit; hold the receiver while the next scan waits
				n = 66;
				thr = 650;
				scans = 2;
				style = STYLE_TOGGLE;
				hold_arm = 1'b1;
			end

			write_reg(lsj_pkg::CFG_BEAM_COUNT, n[lsj_pkg::CFG_DAT_W-1:0]);
			write_reg(lsj_pkg::CFG_JUMP_THRESHOLD, thr[lsj_pkg::CFG_DAT_W-1:0]);
			repeat (scans) queue_scan(n, style, thr);
			if (phase != 1)
				rnd_items += n * scans;
			settle();
			phase++;
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_spans.size() != 0)
			flag_mismatch($sformatf("%0d span beats never arrived", expected_spans.size()));
		if (errors == 0)
			$display("lidar_scan_jump_segmenter_unit regression: pass");
		else
			$display("lidar_scan_jump_segmenter_unit regression: fail");
		$finish;
	end

endmodule
